// ===== rtl/topic_subscription_table_top_assert.svh =====
// Assertion macros for the topic subscription table.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TOPIC_SUBSCRIPTION_TABLE_TOP_ASSERT_SVH
`define TOPIC_SUBSCRIPTION_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define TST_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition never occurs outside reset.
`define TST_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TST_ASSERT(lbl, clk, rstn, prop, msg)
`define TST_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/tst_pkg.sv =====
// Shared types, widths and codes for the topic subscription table.
// No dependencies; imported by the interfaces, tst_cmp, tst_ctrl and the top level.
`default_nettype none

package tst_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int ACTION_W = 2;
	localparam int IP_W     = 32;
	localparam int PORT_W   = 16;
	localparam int TOPIC_W  = 64;
	localparam int STATUS_W = 3;
	localparam int ACTIVE_W = 7;

	// request actions
	localparam logic [ACTION_W-1:0] ACT_SUBSCRIBE   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_UNSUBSCRIBE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PUBLISH     = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_UNUSED      = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FORWARD  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NOSUBS   = 3'd6;

	// one table entry as stored in the RAM
	typedef struct packed {
		logic [IP_W-1:0]    ip;
		logic [PORT_W-1:0]  port;
		logic [TOPIC_W-1:0] topic;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// request held for the duration of a scan
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [IP_W-1:0]     ip;
		logic [PORT_W-1:0]   port;
		logic [TOPIC_W-1:0]  topic;
	} req_t;

	// compare unit result
	typedef struct packed {
		logic topic_eq;
		logic endpoint_eq;
	} match_t;

	// table write request
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} wr_req_t;

	// one result transaction
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IP_W-1:0]     dest_ip;
		logic [PORT_W-1:0]   dest_port;
		logic                last;
		logic [ACTIVE_W-1:0] active_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/tst_req_if.sv =====
// Request channel interface: valid/ready handshake plus request fields.
// Depends on tst_pkg.
`default_nettype none

interface tst_req_if;
	import tst_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [IP_W-1:0]     endpoint_ip;
	logic [PORT_W-1:0]   endpoint_port;
	logic [TOPIC_W-1:0]  topic_key;

	modport source (
		output valid, action, endpoint_ip, endpoint_port, topic_key,
		input  ready
	);

	modport sink (
		input  valid, action, endpoint_ip, endpoint_port, topic_key,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/tst_rsp_if.sv =====
// Result channel interface: valid/ready handshake plus result fields.
// Depends on tst_pkg.
`default_nettype none

interface tst_rsp_if;
	import tst_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IP_W-1:0]     dest_ip;
	logic [PORT_W-1:0]   dest_port;
	logic                last;
	logic [ACTIVE_W-1:0] active_count;

	modport source (
		output valid, status, dest_ip, dest_port, last, active_count,
		input  ready
	);

	modport sink (
		input  valid, status, dest_ip, dest_port, last, active_count,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/tst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tst_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 112,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/tst_cmp.sv =====
// Shared compare unit: matches one table entry against the held request.
// Depends on tst_pkg.
`default_nettype none

module tst_cmp (
	input  wire tst_pkg::entry_t ent,
	input  wire tst_pkg::req_t   key,
	output tst_pkg::match_t      result
);
	import tst_pkg::*;

	// topic compare is shared by all actions; endpoint only by (un)subscribe
	assign result.topic_eq    = (ent.topic == key.topic);
	assign result.endpoint_eq = (ent.ip == key.ip) && (ent.port == key.port);

endmodule

`default_nettype wire

// ===== rtl/tst_ctrl.sv =====
// Scan sequencer: walks the table one entry per cycle unless stalled, tracks
// matches and lowest free slot, updates valid bits and count, drives results.
// Depends on tst_pkg, tst_req_if, tst_rsp_if and the assertion macro header.
`default_nettype none
`include "topic_subscription_table_top_assert.svh"

module tst_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	tst_req_if.sink                     req,
	tst_rsp_if.source                   rsp,
	output logic [tst_pkg::ADDR_W-1:0]  rd_addr,
	input  wire tst_pkg::entry_t        rd_entry,
	input  wire tst_pkg::match_t        hit_info,
	output tst_pkg::req_t               cur_req,
	output tst_pkg::wr_req_t            wr_req
);
	import tst_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
	localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);
	localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(TABLE_DEPTH);

	logic [1:0]             state_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;
	logic                   hit_q;
	logic                   free_found_q;
	logic                   pend_q;
	logic                   rsp_valid_q;

	req_t                   req_q;
	logic [ADDR_W-1:0]      hit_slot_q;
	logic [ADDR_W-1:0]      free_slot_q;
	logic [IP_W-1:0]        pend_ip_q;
	logic [PORT_W-1:0]      pend_port_q;
	rsp_t                   rsp_q;

	logic                   req_fire;
	logic                   out_free;
	logic                   is_pub;
	logic                   ent_valid;
	logic                   hit;
	logic                   stall;
	logic                   advance;
	logic                   scan_push;
	logic                   fin_go;
	logic                   set_valid;
	logic                   clr_valid;
	logic [CNT_W-1:0]       cnt_next;
	rsp_t                   scan_rsp;
	rsp_t                   fin_rsp;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cur_req   = req_q;

	// output register frees up when empty or being taken this cycle
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign is_pub    = (req_q.action == ACT_PUBLISH);
	assign ent_valid = valid_q[addr_q];
	assign hit       = ent_valid && hit_info.topic_eq && (is_pub || hit_info.endpoint_eq);

	// a publish hit with an earlier hit pending must emit that earlier one
	assign stall     = is_pub && hit && pend_q && !out_free;
	assign advance   = (state_q == S_SCAN) && !stall;
	assign scan_push = advance && is_pub && hit && pend_q;
	assign fin_go    = (state_q == S_FINISH) && out_free;

	// read address: entry for the next scan cycle
	always_comb begin
		case (state_q)
			S_SCAN: begin
				if (!advance) begin
					rd_addr = addr_q;
				end else if (addr_q == LAST_ADDR) begin
					rd_addr = '0;
				end else begin
					rd_addr = addr_q + ADDR_ONE;
				end
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	// forward transaction for the previously pending publish hit
	always_comb begin
		scan_rsp.status       = ST_FORWARD;
		scan_rsp.dest_ip      = pend_ip_q;
		scan_rsp.dest_port    = pend_port_q;
		scan_rsp.last         = 1'b0;
		scan_rsp.active_count = ACTIVE_W'(count_q);
	end

	// final transaction and table update at the end of the scan
	always_comb begin
		set_valid           = 1'b0;
		clr_valid           = 1'b0;
		cnt_next            = count_q;
		fin_rsp.status      = ST_NOTFOUND;
		fin_rsp.dest_ip     = '0;
		fin_rsp.dest_port   = '0;
		fin_rsp.last        = 1'b1;
		case (req_q.action)
			ACT_SUBSCRIBE: begin
				if (hit_q) begin
					fin_rsp.status = ST_PRESENT;
				end else if (free_found_q) begin
					fin_rsp.status = ST_ADDED;
					set_valid      = 1'b1;
					cnt_next       = count_q + CNT_ONE;
				end else begin
					fin_rsp.status = ST_FULL;
				end
			end
			ACT_UNSUBSCRIBE: begin
				if (hit_q) begin
					fin_rsp.status = ST_REMOVED;
					clr_valid      = 1'b1;
					if (count_q != '0) begin
						cnt_next = count_q - CNT_ONE;
					end
				end
			end
			ACT_PUBLISH: begin
				if (pend_q) begin
					fin_rsp.status    = ST_FORWARD;
					fin_rsp.dest_ip   = pend_ip_q;
					fin_rsp.dest_port = pend_port_q;
				end else begin
					fin_rsp.status    = ST_NOSUBS;
				end
			end
			default: begin
				fin_rsp.status = ST_NOTFOUND;
			end
		endcase
		fin_rsp.active_count = ACTIVE_W'(cnt_next);
	end

	// table write for a new subscription
	assign wr_req.en   = fin_go && set_valid;
	assign wr_req.addr = free_slot_q;
	assign wr_req.data = '{ip: req_q.ip, port: req_q.port, topic: req_q.topic};

	// sequencer and table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			addr_q       <= '0;
			valid_q      <= '0;
			count_q      <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire && (req.action != ACT_UNUSED)) begin
						state_q      <= S_SCAN;
						addr_q       <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						pend_q       <= 1'b0;
					end
				end
				S_SCAN: begin
					if (advance) begin
						if (hit) begin
							hit_q <= 1'b1;
						end
						if (!ent_valid) begin
							free_found_q <= 1'b1;
						end
						if (is_pub && hit) begin
							pend_q <= 1'b1;
						end
						if (addr_q == LAST_ADDR) begin
							state_q <= S_FINISH;
						end else begin
							addr_q <= addr_q + ADDR_ONE;
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
						count_q <= cnt_next;
						if (set_valid) begin
							valid_q[free_slot_q] <= 1'b1;
						end
						if (clr_valid) begin
							valid_q[hit_slot_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (scan_push || fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q.action <= req.action;
			req_q.ip     <= req.endpoint_ip;
			req_q.port   <= req.endpoint_port;
			req_q.topic  <= req.topic_key;
		end
		if (advance) begin
			if (hit && !hit_q) begin
				hit_slot_q <= addr_q;
			end
			if (!ent_valid && !free_found_q) begin
				free_slot_q <= addr_q;
			end
			if (is_pub && hit) begin
				pend_ip_q   <= rd_entry.ip;
				pend_port_q <= rd_entry.port;
			end
		end
		if (scan_push) begin
			rsp_q <= scan_rsp;
		end else if (fin_go) begin
			rsp_q <= fin_rsp;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.dest_ip      = rsp_q.dest_ip;
	assign rsp.dest_port    = rsp_q.dest_port;
	assign rsp.last         = rsp_q.last;
	assign rsp.active_count = rsp_q.active_count;

	// checks
	`TST_ASSERT(a_cnt_range, clk, arst_n, count_q <= CNT_MAX, "entry count above table depth")
	`TST_ASSERT(a_cnt_finish, clk, arst_n, (count_q != $past(count_q)) |-> ($past(state_q) == S_FINISH), "count changed outside finish")
	`TST_ASSERT_NEVER(a_wr_used, clk, arst_n, wr_req.en && valid_q[wr_req.addr], "write into an occupied slot")
	`TST_ASSERT(a_mid_fwd, clk, arst_n, (rsp_valid_q && !rsp_q.last) |-> (rsp_q.status == ST_FORWARD), "non-final transaction that is not a forward")

endmodule

`default_nettype wire

// ===== rtl/topic_subscription_table_top.sv =====
// Top level of the topic subscription table: table RAM, compare unit, sequencer.
// Depends on tst_pkg, tst_req_if, tst_rsp_if, tst_ram, tst_cmp and tst_ctrl.
`default_nettype none

// Subscription table of TABLE_DEPTH endpoint/topic entries. Each request
// transaction (subscribe, unsubscribe, publish) scans the whole table, one
// entry per cycle unless the result channel holds off a publish scan,
// through the single table RAM read port and the single compare unit. A
// request passes through accept, scan and finish, and req.ready is low
// throughout scan and finish. An unused action code is taken and yields no
// result. Publish results come out in slot order with last on the final one;
// the result register lets the next request be accepted while the final
// result still waits. Valid bits live in flip-flops cleared by reset, so the
// table is usable right after reset with no clearing pass.
module topic_subscription_table_top (
	input  wire logic clk,
	input  wire logic arst_n,
	tst_req_if.sink   req,
	tst_rsp_if.source rsp
);
	import tst_pkg::*;

	logic [ADDR_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	entry_t             rd_entry;
	match_t             hit_info;
	req_t               cur_req;
	wr_req_t            wr_req;

	assign rd_entry = entry_t'(rd_data);

	tst_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_req.en),
		.wr_addr (wr_req.addr),
		.wr_data (wr_req.data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tst_cmp u_cmp (
		.ent    (rd_entry),
		.key    (cur_req),
		.result (hit_info)
	);

	tst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.hit_info (hit_info),
		.cur_req  (cur_req),
		.wr_req   (wr_req)
	);

endmodule

`default_nettype wire
